[rtl/tbi_pkg.sv]
// ----------------------------------------------------------------------------
// tbi_pkg
// Shared constants, codes and types for the table block interleaver.
// ----------------------------------------------------------------------------
package tbi_pkg;

  localparam int MAX_BLOCKS    = 64;
  localparam int MAX_BLOCK_LEN = 16;
  localparam int SYMBOL_BITS   = 8;

  localparam int BLK_W    = $clog2(MAX_BLOCKS);
  localparam int SCNT_W   = (MAX_BLOCK_LEN > 1) ? $clog2(MAX_BLOCK_LEN) : 1;
  localparam int K_W      = 7;
  localparam int S_W      = 5;
  localparam int ADDR_W   = $clog2(MAX_BLOCKS * MAX_BLOCK_LEN);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K_BLOCKS  = 2'd0,
    CFG_BLOCK_LEN = 2'd1
  } tbi_cfg_idx_t;

  typedef enum logic {
    REQ_DATA  = 1'b0,
    REQ_TABLE = 1'b1
  } tbi_req_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym;
    logic                   last;
    logic                   fault;
  } tbi_res_t;

endpackage

[rtl/tbi_if.sv]
// ----------------------------------------------------------------------------
// tbi_if
// Handshake channels of the table block interleaver: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface tbi_req_if import tbi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SYMBOL_BITS-1:0] symbol;
  logic [BLK_W-1:0]       table_index;
  logic [BLK_W-1:0]       table_value;

  modport source (output valid, req_type, symbol, table_index, table_value, input ready);
  modport sink (input valid, req_type, symbol, table_index, table_value, output ready);
endinterface

interface tbi_res_if import tbi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SYMBOL_BITS-1:0] out_symbol;
  logic                   packet_end;
  logic                   table_fault;

  modport source (output valid, out_symbol, packet_end, table_fault, input ready);
  modport sink (input valid, out_symbol, packet_end, table_fault, output ready);
endinterface

interface tbi_cfg_if import tbi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/table_block_interleaver.sv]
// ----------------------------------------------------------------------------
// table_block_interleaver
// Permutes the blocks of each packet through a ping-pong symbol buffer,
// reading the previous packet in table order while the next one is stored.
// ----------------------------------------------------------------------------
// channel  dir  payload                                      handshake
// req      in   req_type, symbol, table_index, table_value   valid/ready
// res      out  out_symbol, packet_end, table_fault          valid/ready
// cfg      in   index, data                                  valid/ready
//
// One word per cycle while ready is high. A result passes through the table read,
// the buffer read, then a four-entry result queue.
// Ready drops only when the queue and the two pipeline stages hold four results.
// Reset is synchronous; both memories come up unwritten and need no clearing.
// Results appear once one full packet is stored, so latency is one packet.
// ----------------------------------------------------------------------------
module table_block_interleaver import tbi_pkg::*; (
  input logic     clk,
  input logic     rst,
  tbi_req_if.sink   req,
  tbi_res_if.source res,
  tbi_cfg_if.sink   cfg
);

  logic [SYMBOL_BITS-1:0] buffer [2*MAX_BLOCKS*MAX_BLOCK_LEN];
  logic [BLK_W-1:0]       perm_table [MAX_BLOCKS];

  logic [K_W-1:0]    k_blocks;
  logic [S_W-1:0]    block_len;
  logic [BLK_W-1:0]  block_count;
  logic [SCNT_W-1:0] symbol_count;
  logic [ADDR_W-1:0] wr_addr;
  logic              write_bank;
  logic              packet_ready;

  logic [BLK_W-1:0]       tbl_q;
  logic [SYMBOL_BITS-1:0] buf_q;

  logic              p1_valid;
  logic              p1_last;
  logic              p1_bank;
  logic [SCNT_W-1:0] p1_sym;
  logic              p2_valid;
  logic              p2_last;
  logic              p2_fault;

  tbi_res_t          fifo [FIFO_DEPTH];
  logic [FPTR_W-1:0] head;
  logic [FPTR_W-1:0] tail;
  logic [FCNT_W-1:0] fifo_cnt;
  logic [FCNT_W-1:0] fifo_cnt_next;
  logic [FCNT_W-1:0] occupancy;

  logic [K_W-1:0]    k_eff;
  logic [S_W-1:0]    s_eff;
  logic              last;
  logic              sym_wrap;
  logic              data_acc;
  logic              tbl_acc;
  logic              cfg_acc;
  logic              push;
  logic              pop;
  logic              p1_fault;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    if (k_blocks == '0) begin
      k_eff = K_W'(1);
    end else if (k_blocks > K_W'(MAX_BLOCKS)) begin
      k_eff = K_W'(MAX_BLOCKS);
    end else begin
      k_eff = k_blocks;
    end
    if (block_len == '0) begin
      s_eff = S_W'(1);
    end else if (block_len > S_W'(MAX_BLOCK_LEN)) begin
      s_eff = S_W'(MAX_BLOCK_LEN);
    end else begin
      s_eff = block_len;
    end
  end

  assign sym_wrap  = S_W'(symbol_count) == s_eff - S_W'(1);
  assign last      = sym_wrap && (K_W'(block_count) == k_eff - K_W'(1));
  assign occupancy = fifo_cnt + FCNT_W'(p1_valid) + FCNT_W'(p2_valid);
  assign req.ready = occupancy < FCNT_W'(FIFO_DEPTH);
  assign cfg.ready = 1'b1;
  assign data_acc  = req.valid && req.ready && (req.req_type == REQ_DATA);
  assign tbl_acc   = req.valid && req.ready && (req.req_type == REQ_TABLE);
  assign cfg_acc   = cfg.valid && cfg.ready;

  assign p1_fault = K_W'(tbl_q) >= k_eff;
  assign rd_addr  = ADDR_W'(tbl_q) * ADDR_W'(s_eff) + ADDR_W'(p1_sym);

  // buffer and table memories, read every cycle
  always_ff @(posedge clk) begin
    if (data_acc) begin
      buffer[{write_bank, wr_addr}] <= req.symbol;
    end
    buf_q <= buffer[{p1_bank, rd_addr}];
    if (tbl_acc) begin
      perm_table[req.table_index] <= req.table_value;
    end
    tbl_q <= perm_table[block_count];
  end

  // packet counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      k_blocks     <= K_W'(1);
      block_len    <= S_W'(1);
      block_count  <= '0;
      symbol_count <= '0;
      wr_addr      <= '0;
      write_bank   <= 1'b0;
      packet_ready <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg.index)
        CFG_K_BLOCKS: begin
          k_blocks     <= K_W'(cfg.data);
          block_count  <= '0;
          symbol_count <= '0;
          wr_addr      <= '0;
          packet_ready <= 1'b0;
        end
        CFG_BLOCK_LEN: begin
          block_len    <= S_W'(cfg.data);
          block_count  <= '0;
          symbol_count <= '0;
          wr_addr      <= '0;
          packet_ready <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (data_acc) begin
      if (last) begin
        block_count  <= '0;
        symbol_count <= '0;
        wr_addr      <= '0;
        write_bank   <= ~write_bank;
        packet_ready <= 1'b1;
      end else if (sym_wrap) begin
        symbol_count <= '0;
        block_count  <= block_count + BLK_W'(1);
        wr_addr      <= wr_addr + ADDR_W'(1);
      end else begin
        symbol_count <= symbol_count + SCNT_W'(1);
        wr_addr      <= wr_addr + ADDR_W'(1);
      end
    end
  end

  // read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= data_acc && packet_ready;
      p2_valid <= p1_valid;
    end
    p1_last  <= last;
    p1_bank  <= ~write_bank;
    p1_sym   <= symbol_count;
    p2_last  <= p1_last;
    p2_fault <= p1_fault;
  end

  // result queue
  assign push = p2_valid;
  assign pop  = res.valid && res.ready;

  always_comb begin
    fifo_cnt_next = fifo_cnt;
    if (push && !pop) begin
      fifo_cnt_next = fifo_cnt + FCNT_W'(1);
    end else if (pop && !push) begin
      fifo_cnt_next = fifo_cnt - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      fifo_cnt <= '0;
    end else begin
      fifo_cnt <= fifo_cnt_next;
      if (push) begin
        tail <= tail + FPTR_W'(1);
      end
      if (pop) begin
        head <= head + FPTR_W'(1);
      end
    end
    if (push) begin
      fifo[tail].sym   <= p2_fault ? '0 : buf_q;
      fifo[tail].last  <= p2_last;
      fifo[tail].fault <= p2_fault;
    end
  end

  assign res.valid       = fifo_cnt != '0;
  assign res.out_symbol  = fifo[head].sym;
  assign res.packet_end  = fifo[head].last;
  assign res.table_fault = fifo[head].fault;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FCNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pipe_flow: assert property (@(posedge clk) disable iff (rst)
    p1_valid |=> p2_valid)
    else $error("pipeline lost a result");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(packet_ready) |-> $past(cfg_acc) || $past(rst))
    else $error("packet ready dropped without a configuration write");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    (ADDR_W + 1)'(wr_addr) < (ADDR_W + 1)'(k_eff) * (ADDR_W + 1)'(s_eff))
    else $error("write address beyond packet");

endmodule
